// File: rtl/esgd_pkg.sv
`default_nettype none
package esgd_pkg;

  localparam int COORD_W    = 11;
  localparam int SH_W       = 11;
  localparam int BAND_W     = 8;
  // signed compare width: covers coordinates and screen height plus two extra bits, one of them the sign
  localparam int CMP_W      = ((COORD_W > SH_W) ? COORD_W : SH_W) + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SH_W;
  localparam int GEST_W     = 3;
  localparam int S_TDATA_W  = ((1 + 2 * COORD_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((GEST_W + 1 + 7) / 8) * 8;

  typedef enum logic [GEST_W-1:0] {
    G_NONE            = GEST_W'(0),
    G_TOP_PRESS       = GEST_W'(1),
    G_BOTTOM_PRESS    = GEST_W'(2),
    G_TOP_SWIPE_DOWN  = GEST_W'(3),
    G_LEFT_SWIPE_IN   = GEST_W'(4),
    G_BOTTOM_SWIPE_UP = GEST_W'(5)
  } gesture_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_HEIGHT   = CFG_IDX_W'(0),
    REG_EDGE_BAND       = CFG_IDX_W'(1),
    REG_SWIPE_THRESHOLD = CFG_IDX_W'(2),
    REG_LEFT_BAND       = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic [SH_W-1:0]   screen_height;
    logic [BAND_W-1:0] edge_band;
    logic [BAND_W-1:0] swipe_threshold;
    logic [BAND_W-1:0] left_band;
  } cfg_t;

  typedef struct packed {
    logic               pressed;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
  } sample_t;

  typedef struct packed {
    gesture_t gesture;
    logic     intercepting;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/esgd_cfg.sv
`default_nettype none
module esgd_cfg
  import esgd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_height   <= SH_W'(480);
      cfg.edge_band       <= BAND_W'(30);
      cfg.swipe_threshold <= BAND_W'(35);
      cfg.left_band       <= BAND_W'(25);
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_SCREEN_HEIGHT:   cfg.screen_height   <= wr_data[SH_W-1:0];
        REG_EDGE_BAND:       cfg.edge_band       <= wr_data[BAND_W-1:0];
        REG_SWIPE_THRESHOLD: cfg.swipe_threshold <= wr_data[BAND_W-1:0];
        REG_LEFT_BAND:       cfg.left_band       <= wr_data[BAND_W-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/esgd_track.sv
`default_nettype none
module esgd_track
  import esgd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire sample_t sample,
  input  wire logic    advance,
  output result_t      result
);

  logic               was_pressed, was_pressed_next;
  logic               tracking, tracking_next;
  logic               intercepted, intercepted_next;
  logic [COORD_W-1:0] start_x, start_x_next;
  logic [COORD_W-1:0] start_y, start_y_next;

  logic               press_edge, held, release_edge;
  logic [COORD_W-1:0] sx, sy;
  logic               top_band, bottom_band, left_start;
  logic signed [CMP_W-1:0] limit, dy, dx, thr;
  gesture_t           gesture;

  always_comb begin
    press_edge   = sample.pressed && !was_pressed;
    held         = sample.pressed && was_pressed && tracking;
    release_edge = !sample.pressed && was_pressed;

    // a press edge tests the bands against the new start
    sx = press_edge ? sample.x_pos : start_x;
    sy = press_edge ? sample.y_pos : start_y;

    top_band    = CMP_W'(sy) < CMP_W'(cfg.edge_band);
    limit       = signed'(CMP_W'(cfg.screen_height)) - signed'(CMP_W'(cfg.edge_band));
    bottom_band = signed'(CMP_W'(sy)) > limit;
    left_start  = CMP_W'(sx) < CMP_W'(cfg.left_band);

    dy  = signed'(CMP_W'(sample.y_pos)) - signed'(CMP_W'(start_y));
    dx  = signed'(CMP_W'(sample.x_pos)) - signed'(CMP_W'(start_x));
    thr = signed'(CMP_W'(cfg.swipe_threshold));

    gesture          = G_NONE;
    tracking_next    = tracking;
    intercepted_next = intercepted;
    start_x_next     = start_x;
    start_y_next     = start_y;

    if (press_edge) begin
      start_x_next     = sample.x_pos;
      start_y_next     = sample.y_pos;
      tracking_next    = 1'b1;
      intercepted_next = 1'b0;
      if (top_band) begin
        gesture = G_TOP_PRESS;
      end else if (bottom_band) begin
        gesture = G_BOTTOM_PRESS;
      end
    end else if (held) begin
      if (top_band && dy > thr) begin
        gesture          = G_TOP_SWIPE_DOWN;
        tracking_next    = 1'b0;
        intercepted_next = 1'b1;
      end else if (left_start && dx > thr) begin
        gesture          = G_LEFT_SWIPE_IN;
        tracking_next    = 1'b0;
        intercepted_next = 1'b1;
      end
    end else if (release_edge) begin
      if (tracking) begin
        if (bottom_band && dy < -thr) begin
          gesture = G_BOTTOM_SWIPE_UP;
        end
        tracking_next = 1'b0;
      end
      intercepted_next = 1'b0;
    end

    was_pressed_next = sample.pressed;

    result.gesture      = gesture;
    result.intercepting = intercepted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed <= 1'b0;
      tracking    <= 1'b0;
      intercepted <= 1'b0;
    end else if (advance) begin
      was_pressed <= was_pressed_next;
      tracking    <= tracking_next;
      intercepted <= intercepted_next;
    end
  end

  // start point is only read while tracking, which a press edge always sets first
  always_ff @(posedge clk) begin
    if (advance) begin
      start_x <= start_x_next;
      start_y <= start_y_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/edge_swipe_gesture_detector.sv
// Channel | Dir | Handshake           | Payload
// s_*     | in  | s_tvalid / s_tready | touch sample: pressed, x_pos, y_pos
// m_*     | out | m_tvalid / m_tready | one result per sample: gesture, intercepting
// cfg_*   | in  | cfg_valid/cfg_ready | register index and write data
//
// One sample per cycle while m_tready keeps up; each sample passes the input register and
// then the result register around the gesture logic before its result is presented.
// rst is synchronous, active high: config registers return to their defaults, state clears.
// A stalled result holds in the result register while one more sample waits
// in the input register; s_tready drops only when both are full.
// cfg_ready is always high.
`default_nettype none
module edge_swipe_gesture_detector
  import esgd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,   // pressed, x_pos, y_pos, zero pad
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_TDATA_W-1:0]       m_tdata,   // gesture, intercepting, zero pad
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  sample_t in_sample;
  logic    in_valid;
  result_t res, out_result;
  logic    out_valid;
  logic    advance;

  assign cfg_ready = 1'b1;

  esgd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // advance a sample into the result register when that slot is free or its result is taken in the same cycle
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample.pressed <= s_tdata[0];
      in_sample.x_pos   <= s_tdata[COORD_W:1];
      in_sample.y_pos   <= s_tdata[2*COORD_W:COORD_W+1];
    end
  end

  esgd_track u_track (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .sample  (in_sample),
    .advance (advance),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'({out_result.intercepting, out_result.gesture});

`ifndef SYNTHESIS
  a_swipe_intercepts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_result.gesture == G_TOP_SWIPE_DOWN ||
                 out_result.gesture == G_LEFT_SWIPE_IN) |-> out_result.intercepting)
    else $error("swipe result without intercept");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_result.gesture == G_BOTTOM_SWIPE_UP ||
                 out_result.gesture == G_TOP_PRESS ||
                 out_result.gesture == G_BOTTOM_PRESS) |-> !out_result.intercepting)
    else $error("press or release result still intercepting");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && out_valid && !m_tready)
    else $error("input stalled while a slot is free");
`endif

endmodule
`default_nettype wire
